// ----- rtl/hsfd_pkg.sv -----
// Shared types and constants of the humidity sensor frame decoder.
`default_nettype none

package hsfd_pkg;

  localparam logic [7:0] CRC_INIT = 8'hFF;
  localparam logic [7:0] CRC_POLY = 8'h31;

  localparam logic [15:0] ID_MASK_RESET  = 16'h083F;
  localparam logic [15:0] ID_VALUE_RESET = 16'h0807;

  localparam logic [30:0] TEMP_SPAN = 31'd17500;
  localparam logic [29:0] HUM_SPAN  = 30'd10000;
  localparam logic signed [14:0] TEMP_OFFSET = -15'sd4500;

  localparam logic CFG_ID_MASK     = 1'b0;
  localparam logic CFG_ID_EXPECTED = 1'b1;

  localparam logic KIND_MEAS = 1'b0;
  localparam logic KIND_IDENT = 1'b1;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_CRC_FAIL = 2'd1,
    ST_ID_FAIL  = 2'd2
  } status_e;

  // Completed frame request handed from the front to the back.
  typedef struct packed {
    logic        kind;
    logic        crc_fail;
    logic [15:0] word_a;
    logic [15:0] word_b;
  } desc_t;

  function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/humidity_sensor_frame_decoder_top.sv -----
// A frame's last byte queues its request; the result register loads it once free.
// Throughput: a byte per cycle unless full; results leave one per cycle when popped.
// full goes high only when the request queue is full, which takes a stalled reader.
// Reset: asynchronous, active low; clears byte position, CRC, queue and result valid,
// and restores id_mask 0x083F and id_expected 0x0807.
`default_nettype none

module humidity_sensor_frame_decoder_top #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push,
  output logic               full,
  input  wire logic [7:0]    rx_byte_i,
  input  wire logic          opcode_i,
  input  wire logic          frame_start_i,
  output logic               empty,
  input  wire logic          pop,
  output logic               frame_kind_o,
  output logic [1:0]         status_o,
  output logic signed [14:0] temperature_centi_o,
  output logic [13:0]        humidity_centi_o,
  output logic [15:0]        id_word_o,
  input  wire logic          cfg_we_i,
  input  wire logic          cfg_idx_i,
  input  wire logic [15:0]   cfg_data_i
);
  import hsfd_pkg::*;

  desc_t front_desc, back_desc;
  logic  front_push;
  logic  q_full, q_empty, q_pop;

  assign full = q_full;

  hsfd_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push_i        (push),
    .full_i        (q_full),
    .rx_byte_i     (rx_byte_i),
    .opcode_i      (opcode_i),
    .frame_start_i (frame_start_i),
    .desc_o        (front_desc),
    .push_o        (front_push)
  );

  hsfd_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (front_push),
    .data_i  (front_desc),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .data_o  (back_desc),
    .empty_o (q_empty)
  );

  hsfd_back u_back (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_we_i            (cfg_we_i),
    .cfg_idx_i           (cfg_idx_i),
    .cfg_data_i          (cfg_data_i),
    .desc_i              (back_desc),
    .desc_empty_i        (q_empty),
    .desc_pop_o          (q_pop),
    .empty_o             (empty),
    .pop_i               (pop),
    .frame_kind_o        (frame_kind_o),
    .status_o            (status_o),
    .temperature_centi_o (temperature_centi_o),
    .humidity_centi_o    (humidity_centi_o),
    .id_word_o           (id_word_o)
  );

endmodule

`default_nettype wire

// ----- rtl/hsfd_front.sv -----
// Byte tracker and CRC checker: assembles frames and emits one request per frame.
`default_nettype none

module hsfd_front (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  wire logic          full_i,
  input  wire logic [7:0]    rx_byte_i,
  input  wire logic          opcode_i,
  input  wire logic          frame_start_i,
  output hsfd_pkg::desc_t    desc_o,
  output logic               push_o
);
  import hsfd_pkg::*;

  localparam logic [2:0] POS_W0_HI  = 3'd0;
  localparam logic [2:0] POS_W0_LO  = 3'd1;
  localparam logic [2:0] POS_W0_CRC = 3'd2;
  localparam logic [2:0] POS_W1_HI  = 3'd3;
  localparam logic [2:0] POS_W1_LO  = 3'd4;
  localparam logic [2:0] POS_W1_CRC = 3'd5;

  logic [2:0]  pos_q, pos_d, pos_cur;
  logic        kind_q, kind_d;
  logic [7:0]  crc_q, crc_d;
  logic [7:0]  hi_q, hi_d;
  logic [15:0] word_a_q, word_a_d;
  logic [15:0] word_b_q, word_b_d;
  logic        fail_q, fail_d;
  logic        accept;
  logic        fail_now;

  assign accept   = push_i && !full_i;
  assign pos_cur  = frame_start_i ? POS_W0_HI : pos_q;
  assign fail_now = fail_q || (crc_q != rx_byte_i);

  always_comb begin
    pos_d    = pos_q;
    kind_d   = kind_q;
    crc_d    = crc_q;
    hi_d     = hi_q;
    word_a_d = word_a_q;
    word_b_d = word_b_q;
    fail_d   = fail_q;
    push_o   = 1'b0;
    desc_o   = '{kind: kind_q, crc_fail: fail_now, word_a: word_a_q, word_b: word_b_q};
    if (accept) begin
      case (pos_cur)
        POS_W0_HI: begin
          kind_d = opcode_i;
          fail_d = 1'b0;
          crc_d  = crc8_byte(CRC_INIT, rx_byte_i);
          hi_d   = rx_byte_i;
          pos_d  = POS_W0_LO;
        end
        POS_W0_LO: begin
          crc_d    = crc8_byte(crc_q, rx_byte_i);
          word_a_d = {hi_q, rx_byte_i};
          pos_d    = POS_W0_CRC;
        end
        POS_W0_CRC: begin
          fail_d = fail_now;
          if (kind_q == KIND_IDENT) begin
            push_o = 1'b1;
            pos_d  = POS_W0_HI;
          end else begin
            pos_d = POS_W1_HI;
          end
        end
        POS_W1_HI: begin
          crc_d = crc8_byte(CRC_INIT, rx_byte_i);
          hi_d  = rx_byte_i;
          pos_d = POS_W1_LO;
        end
        POS_W1_LO: begin
          crc_d    = crc8_byte(crc_q, rx_byte_i);
          word_b_d = {hi_q, rx_byte_i};
          pos_d    = POS_W1_CRC;
        end
        POS_W1_CRC: begin
          fail_d = fail_now;
          push_o = 1'b1;
          pos_d  = POS_W0_HI;
        end
        default: begin
          pos_d = POS_W0_HI;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= POS_W0_HI;
      kind_q   <= KIND_MEAS;
      crc_q    <= CRC_INIT;
      hi_q     <= '0;
      word_a_q <= '0;
      word_b_q <= '0;
      fail_q   <= 1'b0;
    end else begin
      pos_q    <= pos_d;
      kind_q   <= kind_d;
      crc_q    <= crc_d;
      hi_q     <= hi_d;
      word_a_q <= word_a_d;
      word_b_q <= word_b_d;
      fail_q   <= fail_d;
    end
  end

  a_pos_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q != 3'd6 && pos_q != 3'd7)
    else $error("byte position out of range");

  a_push_restarts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o |=> pos_q == POS_W0_HI)
    else $error("frame end did not restart byte position");

  a_push_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o |-> ((desc_o.kind == KIND_IDENT) == (pos_cur == POS_W0_CRC)))
    else $error("request kind does not match frame length");

endmodule

`default_nettype wire

// ----- rtl/hsfd_fifo.sv -----
// Small request queue between the front and the back.
`default_nettype none

module hsfd_fifo #(
  parameter int unsigned DEPTH = 2
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push_i,
  input  wire hsfd_pkg::desc_t data_i,
  output logic                 full_o,
  input  wire logic            pop_i,
  output hsfd_pkg::desc_t      data_o,
  output logic                 empty_o
);
  import hsfd_pkg::*;

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

  desc_t         mem_q [DEPTH];
  logic [PW-1:0] wr_q, rd_q;
  logic [CW-1:0] cnt_q;
  logic          do_push, do_pop;

  assign full_o  = cnt_q == FULL_COUNT;
  assign empty_o = cnt_q == '0;
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == LAST) ? '0 : wr_q + 1'b1;
      end
      if (do_pop) begin
        rd_q <= (rd_q == LAST) ? '0 : rd_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && full_o))
    else $error("request pushed into full queue");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(pop_i && empty_o))
    else $error("request popped from empty queue");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= FULL_COUNT)
    else $error("queue count out of range");

endmodule

`default_nettype wire

// ----- rtl/hsfd_back.sv -----
// Conversion and identity check of completed frames, with the result register.
`default_nettype none

module hsfd_back (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic               cfg_idx_i,
  input  wire logic [15:0]        cfg_data_i,
  input  wire hsfd_pkg::desc_t    desc_i,
  input  wire logic               desc_empty_i,
  output logic                    desc_pop_o,
  output logic                    empty_o,
  input  wire logic               pop_i,
  output logic                    frame_kind_o,
  output logic [1:0]              status_o,
  output logic signed [14:0]      temperature_centi_o,
  output logic [13:0]             humidity_centi_o,
  output logic [15:0]             id_word_o
);
  import hsfd_pkg::*;

  logic [15:0]        mask_q, expect_q;
  logic               valid_q;
  logic               kind_q;
  status_e            status_q, status_d;
  logic signed [14:0] temp_q, temp_d;
  logic [13:0]        hum_q, hum_d;
  logic [15:0]        id_q, id_d;
  logic [30:0]        t_prod;
  logic [29:0]        h_prod;
  logic signed [15:0] temp_sum;
  logic signed [14:0] temp_conv;

  assign desc_pop_o = !desc_empty_i && (!valid_q || pop_i);

  assign t_prod    = 31'(desc_i.word_a) * TEMP_SPAN;
  assign h_prod    = 30'(desc_i.word_b) * HUM_SPAN;
  assign temp_sum  = $signed({1'b0, t_prod[30:16]}) + 16'(TEMP_OFFSET);
  assign temp_conv = $signed(temp_sum[14:0]);

  always_comb begin
    temp_d = '0;
    hum_d  = '0;
    id_d   = '0;
    if (desc_i.kind == KIND_IDENT) begin
      id_d = desc_i.word_a;
      if (desc_i.crc_fail) begin
        status_d = ST_CRC_FAIL;
      end else if ((desc_i.word_a & mask_q) != expect_q) begin
        status_d = ST_ID_FAIL;
      end else begin
        status_d = ST_OK;
      end
    end else if (desc_i.crc_fail) begin
      status_d = ST_CRC_FAIL;
    end else begin
      status_d = ST_OK;
      temp_d   = temp_conv;
      hum_d    = h_prod[29:16];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q   <= ID_MASK_RESET;
      expect_q <= ID_VALUE_RESET;
      valid_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_ID_MASK:     mask_q   <= cfg_data_i;
          CFG_ID_EXPECTED: expect_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (desc_pop_o) begin
        valid_q <= 1'b1;
      end else if (pop_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (desc_pop_o) begin
      kind_q   <= desc_i.kind;
      status_q <= status_d;
      temp_q   <= temp_d;
      hum_q    <= hum_d;
      id_q     <= id_d;
    end
  end

  assign empty_o             = !valid_q;
  assign frame_kind_o        = kind_q;
  assign status_o            = status_q;
  assign temperature_centi_o = temp_q;
  assign humidity_centi_o    = hum_q;
  assign id_word_o           = id_q;

  a_load_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    desc_pop_o |=> valid_q)
    else $error("loaded result not marked valid");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && !pop_i) |-> !desc_pop_o)
    else $error("pending result overwritten");

  a_meas_no_id: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && kind_q == KIND_MEAS) |-> (id_q == '0 && status_q != ST_ID_FAIL))
    else $error("measurement result carries identity data");

endmodule

`default_nettype wire
